/* rtl/eta_phi_momentum_to_cartesian_unit_macros.svh */
// Assertion macros shared by the checker of the eta/phi to Cartesian unit.
`ifndef ETA_PHI_MOMENTUM_TO_CARTESIAN_UNIT_MACROS_SVH
`define ETA_PHI_MOMENTUM_TO_CARTESIAN_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EPMC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("epmc assertion failed");

// Next-cycle implication, checked outside reset.
`define EPMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("epmc assertion failed");

`endif

/* rtl/epmc_pkg.sv */
// Package with widths, constants and shared types of the eta/phi momentum converter.
package epmc_pkg;

    localparam int MOM_BITS    = 24;
    localparam int OUT_BITS    = MOM_BITS + 1;
    localparam int FRAC_BITS   = 30;
    localparam int EXP_TERMS   = 20;
    localparam int TRIG_TERMS  = 10;
    localparam int EXP_INT_MAX = 8;

    localparam longint unsigned ONE_Q30 = 64'd1 << FRAC_BITS;
    localparam longint unsigned PI_Q30  = 64'd3373259426;

    // Pipeline latencies, counted in registers.
    localparam int EXP_LAT  = 2 * EXP_TERMS + EXP_INT_MAX + 1;
    localparam int TRIG_LAT = 3 * TRIG_TERMS + 2;
    localparam int DIV_LAT  = OUT_BITS + 1;

    // Quadrant codes of the binary angle.
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    typedef logic [FRAC_BITS:0] q30_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] sy;
    } epmc_trig_t;

    // exp(-1) in Q30 exactly as the truncating 20-term series yields it.
    localparam q30_t EXP_M1 = 31'd395007543;

endpackage

/* rtl/eta_phi_momentum_to_cartesian_unit.sv */
// Top level: converts (p, eta, phi) particles into saturated Cartesian momentum components.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | momentum, pseudorapidity, azimuth, last_particle
//  m_      | out       | m_valid / m_ready  | mom_x, mom_y, mom_z, last_out
//
// One transaction enters per clock while s_ready is high; its result is presented on m_valid
// once it has passed every stage and can be taken at the following edge.
// The latency is set by the exp(-|eta|) series (two stages per term), the eight exp(-1)
// scaling stages and one restoring divider stage per quotient bit.
// Reset (aresetn low, synchronous) clears the valid bits only; data registers are not reset.
// When the output register holds an untaken result, the whole pipeline freezes in place and
// s_ready goes low, so nothing is dropped or repeated.
module eta_phi_momentum_to_cartesian_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [epmc_pkg::MOM_BITS-1:0]         s_momentum,
    input  logic signed [15:0]                    s_pseudorapidity,
    input  logic signed [15:0]                    s_azimuth,
    input  logic                                  s_last_particle,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [epmc_pkg::OUT_BITS-1:0]  m_mom_x,
    output logic signed [epmc_pkg::OUT_BITS-1:0]  m_mom_y,
    output logic signed [epmc_pkg::OUT_BITS-1:0]  m_mom_z,
    output logic                                  m_last_out
);

    localparam int MB = epmc_pkg::MOM_BITS;
    localparam int OB = epmc_pkg::OUT_BITS;
    // Stage numbers counted from the input register (stage 0).
    localparam int DIV_OUT   = epmc_pkg::EXP_LAT + epmc_pkg::DIV_LAT;
    localparam int SCALE_STG = DIV_OUT + 1;
    localparam int TRIG_DLY  = DIV_OUT - epmc_pkg::TRIG_LAT;

    // The pipeline advances as one: whenever the output register is empty or being taken.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Valid bits travel beside the data, from the input register to the scale stage.
    logic vld_reg [0:SCALE_STG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= SCALE_STG; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i <= SCALE_STG; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Input register: eta is folded to its magnitude, split into integer and fraction;
    // phi is split into its quadrant and the angle within that quadrant.
    logic [15:0]   eta_abs;
    logic [MB-1:0] p0_reg;
    logic [11:0]   frac0_reg;
    logic [3:0]    int0_reg;
    logic [13:0]   rem0_reg;
    logic [1:0]    quad0_reg;
    logic          neg0_reg;
    logic          last0_reg;

    assign eta_abs = s_pseudorapidity[15] ? 16'(-s_pseudorapidity) : 16'(s_pseudorapidity);

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg    <= s_momentum;
            frac0_reg <= eta_abs[11:0];
            int0_reg  <= eta_abs[15:12];
            rem0_reg  <= s_azimuth[13:0];
            quad0_reg <= s_azimuth[15:14];
            neg0_reg  <= s_pseudorapidity[15];
            last0_reg <= s_last_particle;
        end
    end

    // Polar part: e = exp(-|eta|) and its square.
    epmc_pkg::q30_t e_w;
    epmc_pkg::q30_t e2_w;

    epmc_exp_unit u_exp (
        .aclk    (aclk),
        .en      (en),
        .frac_in (frac0_reg),
        .int_in  (int0_reg),
        .e_out   (e_w),
        .e2_out  (e2_w)
    );

    // Azimuthal part: signed cosine and sine of phi.
    epmc_pkg::epmc_trig_t trig_w;

    epmc_trig_unit u_trig (
        .aclk     (aclk),
        .en       (en),
        .rem_in   (rem0_reg),
        .quad_in  (quad0_reg),
        .trig_out (trig_w)
    );

    // Momentum waits for e; the trig result waits for the dividers.
    logic [MB-1:0]        p_dly_reg [0:epmc_pkg::EXP_LAT-1];
    epmc_pkg::epmc_trig_t trig_dly_reg [0:TRIG_DLY-1];
    logic [1:0]           side_dly_reg [0:SCALE_STG-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_dly_reg[0] <= p0_reg;
            for (int i = 1; i < epmc_pkg::EXP_LAT; i++) begin
                p_dly_reg[i] <= p_dly_reg[i-1];
            end
            trig_dly_reg[0] <= trig_w;
            for (int i = 1; i < TRIG_DLY; i++) begin
                trig_dly_reg[i] <= trig_dly_reg[i-1];
            end
            side_dly_reg[0] <= {neg0_reg, last0_reg};
            for (int i = 1; i < SCALE_STG; i++) begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
        end
    end

    // Longitudinal magnitude and transverse momentum.
    logic [OB-1:0] zmag_w;
    logic [OB-1:0] pt_w;

    epmc_div_unit u_div (
        .aclk     (aclk),
        .en       (en),
        .mom_in   (p_dly_reg[epmc_pkg::EXP_LAT-1]),
        .e_in     (e_w),
        .e2_in    (e2_w),
        .zmag_out (zmag_w),
        .pt_out   (pt_w)
    );

    // Scale stage: pt times |cos| and |sin|, rounded half up.
    epmc_pkg::epmc_trig_t trig_al;
    logic [30:0]          abs_c;
    logic [30:0]          abs_s;
    logic [OB+30:0]       px_prod;
    logic [OB+30:0]       py_prod;
    logic [OB:0]          xmag_reg;
    logic [OB:0]          ymag_reg;
    logic                 xneg_reg;
    logic                 yneg_reg;
    logic [OB-1:0]        zmag_reg;

    assign trig_al = trig_dly_reg[TRIG_DLY-1];
    assign abs_c   = trig_al.cx[31] ? 31'(-trig_al.cx) : trig_al.cx[30:0];
    assign abs_s   = trig_al.sy[31] ? 31'(-trig_al.sy) : trig_al.sy[30:0];
    assign px_prod = pt_w * abs_c + (OB + 31)'(64'd1 << 29);
    assign py_prod = pt_w * abs_s + (OB + 31)'(64'd1 << 29);

    always_ff @(posedge aclk) begin
        if (en) begin
            xmag_reg <= px_prod[OB+30:30];
            ymag_reg <= py_prod[OB+30:30];
            xneg_reg <= trig_al.cx[31];
            yneg_reg <= trig_al.sy[31];
            zmag_reg <= zmag_w;
        end
    end

    // Signs are applied and every component is clamped to the output range.
    function automatic logic signed [OB-1:0] sat_signed(input logic [OB:0] mag, input logic neg);
        if (!neg) begin
            if (mag > (OB + 1)'({MB{1'b1}})) begin
                return {1'b0, {MB{1'b1}}};
            end
            return OB'(mag);
        end
        if (mag >= ((OB + 1)'(1) << MB)) begin
            return {1'b1, {MB{1'b0}}};
        end
        return OB'(-mag);
    endfunction

    logic                 m_valid_reg;
    logic signed [OB-1:0] mx_reg;
    logic signed [OB-1:0] my_reg;
    logic signed [OB-1:0] mz_reg;
    logic                 mlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[SCALE_STG];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg    <= sat_signed(xmag_reg, xneg_reg);
            my_reg    <= sat_signed(ymag_reg, yneg_reg);
            mz_reg    <= sat_signed({1'b0, zmag_reg}, side_dly_reg[SCALE_STG-1][1]);
            mlast_reg <= side_dly_reg[SCALE_STG-1][0];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_mom_x    = mx_reg;
    assign m_mom_y    = my_reg;
    assign m_mom_z    = mz_reg;
    assign m_last_out = mlast_reg;

endmodule

/* rtl/epmc_exp_unit.sv */
// Pipelined exp(-|eta|) series with integer-part scaling and squaring.
module epmc_exp_unit (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [11:0]           frac_in,
    input  logic [3:0]            int_in,
    output epmc_pkg::q30_t        e_out,
    output epmc_pkg::q30_t        e2_out
);

    localparam int NT = epmc_pkg::EXP_TERMS;
    localparam int NC = epmc_pkg::EXP_INT_MAX;
    localparam int FB = epmc_pkg::FRAC_BITS;

    typedef struct packed {
        logic signed [32:0] s;
        logic [29:0]        x;
        logic [3:0]         n;
    } exp_side_t;

    logic [30:0] m_reg [1:NT];
    exp_side_t   mside_reg [1:NT];
    logic [30:0] t_reg [1:NT];
    exp_side_t   tside_reg [1:NT];

    for (genvar k = 1; k <= NT; k++) begin : g_term
        localparam int              SH  = 31 + $clog2(k);
        localparam longint unsigned MUL = ((64'd1 << SH) + k - 1) / k;
        logic [30:0] t_prev;
        exp_side_t   side_prev;
        logic [60:0] prod;
        logic [62:0] qprod;
        logic [30:0] q;
        if (k == 1) begin : g_first
            assign t_prev      = 31'(epmc_pkg::ONE_Q30);
            assign side_prev.s = 33'(epmc_pkg::ONE_Q30);
            assign side_prev.x = {frac_in, 18'd0};
            assign side_prev.n = int_in;
        end else begin : g_next
            assign t_prev    = t_reg[k-1];
            assign side_prev = tside_reg[k-1];
        end
        assign prod  = t_prev * side_prev.x;
        assign qprod = m_reg[k] * 32'(MUL);
        assign q     = 31'(qprod >> SH);
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[k]       <= prod[60:FB];
                mside_reg[k]   <= side_prev;
                t_reg[k]       <= q;
                tside_reg[k].x <= mside_reg[k].x;
                tside_reg[k].n <= mside_reg[k].n;
                if ((k % 2) == 1) begin
                    tside_reg[k].s <= mside_reg[k].s - $signed({2'b00, q});
                end else begin
                    tside_reg[k].s <= mside_reg[k].s + $signed({2'b00, q});
                end
            end
        end
    end

    // Clamp of the series sum to [0, 1].
    epmc_pkg::q30_t e_first;
    always_comb begin
        if (tside_reg[NT].s < 0) begin
            e_first = '0;
        end else if (tside_reg[NT].s > $signed(33'(epmc_pkg::ONE_Q30))) begin
            e_first = epmc_pkg::q30_t'(epmc_pkg::ONE_Q30);
        end else begin
            e_first = tside_reg[NT].s[30:0];
        end
    end

    // One multiply by exp(-1) per stage, applied while the stage index is below n.
    epmc_pkg::q30_t e_reg [0:NC-1];
    logic [3:0]     n_reg [0:NC-1];

    for (genvar i = 0; i < NC; i++) begin : g_chain
        epmc_pkg::q30_t e_prev;
        logic [3:0]     n_prev;
        logic [61:0]    prod;
        if (i == 0) begin : g_first
            assign e_prev = e_first;
            assign n_prev = tside_reg[NT].n;
        end else begin : g_next
            assign e_prev = e_reg[i-1];
            assign n_prev = n_reg[i-1];
        end
        assign prod = e_prev * epmc_pkg::EXP_M1;
        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[i] <= n_prev;
                if (n_prev > 4'(i)) begin
                    e_reg[i] <= epmc_pkg::q30_t'(prod >> FB);
                end else begin
                    e_reg[i] <= e_prev;
                end
            end
        end
    end

    logic [61:0]    sq;
    epmc_pkg::q30_t e_fin_reg;
    epmc_pkg::q30_t e2_reg;

    assign sq = e_reg[NC-1] * e_reg[NC-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            e_fin_reg <= e_reg[NC-1];
            e2_reg    <= epmc_pkg::q30_t'(sq >> FB);
        end
    end

    assign e_out  = e_fin_reg;
    assign e2_out = e2_reg;

endmodule

/* rtl/epmc_trig_unit.sv */
// Pipelined sine and cosine series of the binary angle, mapped to its quadrant.
module epmc_trig_unit (
    input  logic                aclk,
    input  logic                en,
    input  logic [13:0]         rem_in,
    input  logic [1:0]          quad_in,
    output epmc_pkg::epmc_trig_t trig_out
);

    localparam int NT = epmc_pkg::TRIG_TERMS;
    localparam int FB = epmc_pkg::FRAC_BITS;

    typedef struct packed {
        logic signed [33:0] c;
        logic signed [33:0] s;
        logic [30:0]        x;
        logic [1:0]         quad;
    } trig_side_t;

    logic [45:0] xprod;
    trig_side_t  x_reg;

    assign xprod = rem_in * 32'(epmc_pkg::PI_Q30);

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg.x    <= 31'(xprod >> 15);
            x_reg.c    <= 34'(epmc_pkg::ONE_Q30);
            x_reg.s    <= $signed({3'b000, 31'(xprod >> 15)});
            x_reg.quad <= quad_in;
        end
    end

    logic [31:0] ca_reg [1:NT];
    logic [31:0] sa_reg [1:NT];
    trig_side_t  aside_reg [1:NT];
    logic [31:0] cb_reg [1:NT];
    logic [31:0] sb_reg [1:NT];
    trig_side_t  bside_reg [1:NT];
    logic [30:0] tc_reg [1:NT];
    logic [30:0] ts_reg [1:NT];
    trig_side_t  tside_reg [1:NT];

    for (genvar k = 1; k <= NT; k++) begin : g_term
        localparam int              DC   = (2 * k - 1) * (2 * k);
        localparam int              DS   = (2 * k) * (2 * k + 1);
        localparam int              SHC  = 32 + $clog2(DC);
        localparam int              SHS  = 32 + $clog2(DS);
        localparam longint unsigned MULC = ((64'd1 << SHC) + DC - 1) / DC;
        localparam longint unsigned MULS = ((64'd1 << SHS) + DS - 1) / DS;
        logic [30:0] tc_prev;
        logic [30:0] ts_prev;
        trig_side_t  side_prev;
        logic [61:0] pa_c;
        logic [61:0] pa_s;
        logic [62:0] pb_c;
        logic [62:0] pb_s;
        logic [64:0] qc_prod;
        logic [64:0] qs_prod;
        logic [30:0] qc;
        logic [30:0] qs;
        if (k == 1) begin : g_first
            assign tc_prev   = 31'(epmc_pkg::ONE_Q30);
            assign ts_prev   = x_reg.x;
            assign side_prev = x_reg;
        end else begin : g_next
            assign tc_prev   = tc_reg[k-1];
            assign ts_prev   = ts_reg[k-1];
            assign side_prev = tside_reg[k-1];
        end
        assign pa_c    = tc_prev * side_prev.x;
        assign pa_s    = ts_prev * side_prev.x;
        assign pb_c    = ca_reg[k] * aside_reg[k].x;
        assign pb_s    = sa_reg[k] * aside_reg[k].x;
        assign qc_prod = cb_reg[k] * 33'(MULC);
        assign qs_prod = sb_reg[k] * 33'(MULS);
        assign qc      = 31'(qc_prod >> SHC);
        assign qs      = 31'(qs_prod >> SHS);
        always_ff @(posedge aclk) begin
            if (en) begin
                ca_reg[k]         <= pa_c[61:FB];
                sa_reg[k]         <= pa_s[61:FB];
                aside_reg[k]      <= side_prev;
                cb_reg[k]         <= pb_c[61:FB];
                sb_reg[k]         <= pb_s[61:FB];
                bside_reg[k]      <= aside_reg[k];
                tc_reg[k]         <= qc;
                ts_reg[k]         <= qs;
                tside_reg[k].x    <= bside_reg[k].x;
                tside_reg[k].quad <= bside_reg[k].quad;
                if ((k % 2) == 1) begin
                    tside_reg[k].c <= bside_reg[k].c - $signed({3'b000, qc});
                    tside_reg[k].s <= bside_reg[k].s - $signed({3'b000, qs});
                end else begin
                    tside_reg[k].c <= bside_reg[k].c + $signed({3'b000, qc});
                    tside_reg[k].s <= bside_reg[k].s + $signed({3'b000, qs});
                end
            end
        end
    end

    function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
        if (v < 0) begin
            return '0;
        end
        if (v > $signed(34'(epmc_pkg::ONE_Q30))) begin
            return 32'(epmc_pkg::ONE_Q30);
        end
        return 32'(v);
    endfunction

    logic signed [31:0]   sn;
    logic signed [31:0]   cs;
    epmc_pkg::epmc_trig_t trig_next;
    epmc_pkg::epmc_trig_t trig_reg;

    always_comb begin
        sn = clamp_unit(tside_reg[NT].s);
        cs = clamp_unit(tside_reg[NT].c);
        unique case (tside_reg[NT].quad)
            epmc_pkg::QUAD_I: begin
                trig_next.cx = cs;
                trig_next.sy = sn;
            end
            epmc_pkg::QUAD_II: begin
                trig_next.cx = -sn;
                trig_next.sy = cs;
            end
            epmc_pkg::QUAD_III: begin
                trig_next.cx = -cs;
                trig_next.sy = -sn;
            end
            epmc_pkg::QUAD_IV: begin
                trig_next.cx = sn;
                trig_next.sy = -cs;
            end
            default: begin
                trig_next.cx = cs;
                trig_next.sy = sn;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg <= trig_next;
        end
    end

    assign trig_out = trig_reg;

endmodule

/* rtl/epmc_div_unit.sv */
// Two pipelined restoring dividers for p*tanh|eta| and p/cosh(eta), rounded half up.
module epmc_div_unit (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [epmc_pkg::MOM_BITS-1:0]     mom_in,
    input  epmc_pkg::q30_t                    e_in,
    input  epmc_pkg::q30_t                    e2_in,
    output logic [epmc_pkg::OUT_BITS-1:0]     zmag_out,
    output logic [epmc_pkg::OUT_BITS-1:0]     pt_out
);

    localparam int QB = epmc_pkg::OUT_BITS;
    localparam int NW = epmc_pkg::MOM_BITS + 33;

    typedef struct packed {
        logic [31:0]   rz;
        logic [QB-1:0] lz;
        logic [31:0]   rt;
        logic [QB-1:0] lt;
        logic [31:0]   den;
    } div_state_t;

    logic [31:0]   den;
    logic [NW-1:0] num_z;
    logic [NW-1:0] num_t;
    div_state_t    st_reg [0:QB];

    assign den   = 32'(epmc_pkg::ONE_Q30) + 32'(e2_in);
    assign num_z = NW'(mom_in) * NW'(31'(epmc_pkg::ONE_Q30) - e2_in) + NW'(den >> 1);
    assign num_t = NW'(mom_in) * NW'({e_in, 1'b0}) + NW'(den >> 1);

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].rz  <= 32'(num_z >> QB);
            st_reg[0].lz  <= num_z[QB-1:0];
            st_reg[0].rt  <= 32'(num_t >> QB);
            st_reg[0].lt  <= num_t[QB-1:0];
            st_reg[0].den <= den;
        end
    end

    // One quotient bit per stage for both dividers.
    for (genvar i = 1; i <= QB; i++) begin : g_step
        logic [32:0] tz;
        logic [32:0] tt;
        div_state_t  st_next;
        assign tz = {st_reg[i-1].rz, st_reg[i-1].lz[QB-1]};
        assign tt = {st_reg[i-1].rt, st_reg[i-1].lt[QB-1]};
        always_comb begin
            st_next.den = st_reg[i-1].den;
            if (tz >= {1'b0, st_reg[i-1].den}) begin
                st_next.rz = 32'(tz - {1'b0, st_reg[i-1].den});
                st_next.lz = {st_reg[i-1].lz[QB-2:0], 1'b1};
            end else begin
                st_next.rz = 32'(tz);
                st_next.lz = {st_reg[i-1].lz[QB-2:0], 1'b0};
            end
            if (tt >= {1'b0, st_reg[i-1].den}) begin
                st_next.rt = 32'(tt - {1'b0, st_reg[i-1].den});
                st_next.lt = {st_reg[i-1].lt[QB-2:0], 1'b1};
            end else begin
                st_next.rt = 32'(tt);
                st_next.lt = {st_reg[i-1].lt[QB-2:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i] <= st_next;
            end
        end
    end

    assign zmag_out = st_reg[QB].lz;
    assign pt_out   = st_reg[QB].lt;

endmodule

/* rtl/epmc_checker.sv */
// Port-level checker of the eta/phi momentum converter and its bind statement.
`include "eta_phi_momentum_to_cartesian_unit_macros.svh"

module epmc_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [epmc_pkg::OUT_BITS-1:0]  m_mom_x,
    input logic signed [epmc_pkg::OUT_BITS-1:0]  m_mom_y,
    input logic signed [epmc_pkg::OUT_BITS-1:0]  m_mom_z,
    input logic                                  m_last_out
);

    // An empty output register never blocks the input side.
    `EPMC_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)
    // A result being taken always frees a slot for a new transaction.
    `EPMC_ASSERT_NOW(a_ready_when_taken, m_valid && m_ready, s_ready)
    // Input is refused only while a result waits.
    `EPMC_ASSERT_NOW(a_stall_cause, !s_ready, m_valid && !m_ready)
    // A stalled result holds its value.
    `EPMC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_mom_x) && $stable(m_mom_y) && $stable(m_mom_z) && $stable(m_last_out))

endmodule

bind eta_phi_momentum_to_cartesian_unit epmc_checker u_epmc_checker (.*);

/* sim/eta_phi_momentum_to_cartesian_unit_checker.sv */
// Checker that predicts and compares the Cartesian momentum of each particle.
module eta_phi_momentum_to_cartesian_unit_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [epmc_pkg::MOM_BITS-1:0]         s_momentum,
    input  logic signed [15:0]                    s_pseudorapidity,
    input  logic signed [15:0]                    s_azimuth,
    input  logic                                  s_last_particle,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic signed [epmc_pkg::OUT_BITS-1:0]  m_mom_x,
    input  logic signed [epmc_pkg::OUT_BITS-1:0]  m_mom_y,
    input  logic signed [epmc_pkg::OUT_BITS-1:0]  m_mom_z,
    input  logic                                  m_last_out,
    output int                                    fail_count,
    output int                                    pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MB = epmc_pkg::MOM_BITS;
    localparam int OB = epmc_pkg::OUT_BITS;
    localparam longint unsigned ONE = epmc_pkg::ONE_Q30;

    typedef struct packed {
        logic signed [OB-1:0] px;
        logic signed [OB-1:0] py;
        logic signed [OB-1:0] pz;
        logic                 last;
    } cart_t;

    cart_t cart_queue[$];

    function automatic longint unit_clamp(input longint v);
        if (v < 0) return 0;
        if (v > longint'(ONE)) return longint'(ONE);
        return v;
    endfunction

    // Truncating alternating series for exp(-x), x in Q30.
    function automatic longint decay_q30(input longint unsigned x);
        longint unsigned t;
        longint          s;
        t = ONE;
        s = longint'(ONE);
        for (int k = 1; k <= 20; k++) begin
            t = ((t * x) >> 30) / longint'(k);
            if (k % 2 == 1) s -= longint'(t);
            else s += longint'(t);
        end
        return unit_clamp(s);
    endfunction

    function automatic longint clip_out(input longint v);
        longint hi;
        hi = (longint'(1) << MB) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint project(input longint unsigned m, input longint f);
        longint unsigned a;
        longint          r;
        a = (f < 0) ? longint'(-f) : f;
        r = longint'((m * a + (64'd1 << 29)) >> 30);
        return (f < 0) ? -r : r;
    endfunction

    function automatic cart_t convert_particle(input logic [MB-1:0] mom,
                                               input logic [15:0] eta,
                                               input logic [15:0] phi,
                                               input logic last);
        longint unsigned p, a, n, r, x, tc, ts, zmag, pt;
        longint e, em1, e2, den, c, s, cx, sy;
        cart_t res;
        p = mom;
        a = eta[15] ? (64'h10000 - eta) : eta;
        n = a >> 12;
        e = decay_q30((a & 64'hFFF) << 18);
        em1 = decay_q30(ONE);
        for (longint unsigned i = 0; i < n; i++)
            e = longint'((longint'(e) * em1) >> 30);
        e2 = longint'((longint'(e) * e) >> 30);
        den = longint'(ONE) + e2;
        zmag = (p * longint'(longint'(ONE) - e2) + den / 2) / den;
        pt = (p * longint'(2 * e) + den / 2) / den;

        r = phi[13:0];
        x = (r * epmc_pkg::PI_Q30) >> 15;
        tc = ONE;
        ts = x;
        c = longint'(ONE);
        s = x;
        for (int k = 1; k <= 10; k++) begin
            tc = ((((tc * x) >> 30) * x) >> 30) / longint'((2 * k - 1) * (2 * k));
            ts = ((((ts * x) >> 30) * x) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                c -= tc;
                s -= ts;
            end else begin
                c += tc;
                s += ts;
            end
        end
        s = unit_clamp(s);
        c = unit_clamp(c);
        case (phi[15:14])
            epmc_pkg::QUAD_I:   begin cx = c;  sy = s;  end
            epmc_pkg::QUAD_II:  begin cx = -s; sy = c;  end
            epmc_pkg::QUAD_III: begin cx = -c; sy = -s; end
            default:            begin cx = s;  sy = -c; end
        endcase
        res.px = OB'(clip_out(project(pt, cx)));
        res.py = OB'(clip_out(project(pt, sy)));
        res.pz = OB'(clip_out(eta[15] ? -longint'(zmag) : longint'(zmag)));
        res.last = last;
        return res;
    endfunction

    initial begin
        fail_count = 0;
        pending_count = 0;
    end

    always @(posedge aclk) begin
        cart_t want;
        if (aresetn && s_valid && s_ready)
            cart_queue.push_back(convert_particle(s_momentum, s_pseudorapidity,
                                                  s_azimuth, s_last_particle));
        if (aresetn && m_valid && m_ready) begin
            if (cart_queue.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d last=%0b", $time,
                         m_mom_x, m_mom_y, m_mom_z, m_last_out);
                fail_count++;
            end else begin
                want = cart_queue.pop_front();
                if (m_mom_x !== want.px) begin
                    $display("%0t: mom_x expected %0d actual %0d", $time, want.px, m_mom_x);
                    fail_count++;
                end
                if (m_mom_y !== want.py) begin
                    $display("%0t: mom_y expected %0d actual %0d", $time, want.py, m_mom_y);
                    fail_count++;
                end
                if (m_mom_z !== want.pz) begin
                    $display("%0t: mom_z expected %0d actual %0d", $time, want.pz, m_mom_z);
                    fail_count++;
                end
                if (m_last_out !== want.last) begin
                    $display("%0t: last_out expected %0b actual %0b", $time, want.last,
                             m_last_out);
                    fail_count++;
                end
            end
        end
        pending_count = cart_queue.size();
    end
endmodule

/* sim/eta_phi_momentum_to_cartesian_unit_test.sv */
// Testbench top that drives particles into the converter and gives the verdict.
module eta_phi_momentum_to_cartesian_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MB = epmc_pkg::MOM_BITS;
    localparam int OB = epmc_pkg::OUT_BITS;

    // Drain time waited once no expected result is still pending.
    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 650;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [MB-1:0]         s_momentum = '0;
    logic signed [15:0]    s_pseudorapidity = '0;
    logic signed [15:0]    s_azimuth = '0;
    logic                  s_last_particle = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [OB-1:0]  m_mom_x, m_mom_y, m_mom_z;
    logic                  m_last_out;
    int                    fail_count, pending_count;
    int                    idle_cycles = 0;

    always #4 aclk = ~aclk;

    eta_phi_momentum_to_cartesian_unit DUT (.*);

    eta_phi_momentum_to_cartesian_unit_checker checker_inst (.*);

    // Watchdog: counts cycles in which no transaction happens on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // The receiver draws a random stall before each result it takes.
    // Some stretches run with no stall at all so the pipeline sees back-to-back results.
    initial begin
        int wait_n;
        @(posedge aclk iff aresetn);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    // Presents one particle and holds it until the transaction is accepted.
    // A gap of zero keeps valid high across consecutive transactions.
    task automatic send_particle(input logic [MB-1:0] mom, input logic [15:0] eta,
                                 input logic [15:0] phi, input logic last, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_momentum <= mom;
        s_pseudorapidity <= eta;
        s_azimuth <= phi;
        s_last_particle <= last;
        @(posedge aclk iff s_ready);
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    endfunction

    initial begin
        logic [15:0] eta_corner[6];
        logic [15:0] phi_corner[8];
        logic [MB-1:0] mom;
        eta_corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h1000, 16'hF000};
        phi_corner = '{16'h0000, 16'h3FFF, 16'h4000, 16'h8000, 16'hC000,
                       16'h7FFF, 16'hFFFF, 16'h2000};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: extreme eta (including exactly -8), every quadrant
        // boundary of phi, zero and full-scale momentum, and the last-particle mark.
        for (int i = 0; i < 6; i++)
            send_particle({MB{1'b1}}, eta_corner[i], phi_corner[i], i[0], draw_gap());
        for (int i = 0; i < 8; i++)
            send_particle(MB'($urandom), eta_corner[i % 6], phi_corner[i], 1'b0, 0);
        send_particle('0, 16'h8000, 16'h2000, 1'b1, 0);
        send_particle('0, 16'h0000, 16'h0000, 1'b0, 1);
        send_particle({MB{1'b1}}, 16'h0000, 16'hA000, 1'b1, 0);
        send_particle(MB'(1), 16'h7FFF, 16'h6000, 1'b0, 2);

        // Random particles grouped into events, with momentum spread over all magnitudes.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            mom = MB'($urandom) >> $urandom_range(0, MB - 1);
            send_particle(mom, 16'($urandom), 16'($urandom),
                          ($urandom_range(0, 4) == 0), draw_gap());
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
